### rtl/core/ptsb_pkg.sv
// shared types and constants for the periodic timer slot bank
// no dependencies; used by every module of the block but ptsb_ram by scoped names
`timescale 1ns / 1ps

package ptsb_pkg;

  localparam int NUM_SLOTS_DEF = 8;
  localparam int MAX_RESULTS   = 8;
  localparam int REP_W         = 4;   // holds 0..MAX_RESULTS

  localparam int CMD_W     = 2;
  localparam int TGT_W     = 16;
  localparam int IDX_W     = 3;
  localparam int KIND_W    = 3;
  localparam int ELAPSED_W = 17;
  localparam int IN_DATA_W  = 24;     // cmd, target_ticks, slot_index, zero fill
  localparam int OUT_DATA_W = 8;      // event_kind, slot_number, zero fill

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 2'd0,
    CMD_ALLOC   = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE     = 3'd0,
    KIND_FIRED    = 3'd1,
    KIND_ALLOC    = 3'd2,
    KIND_FULL     = 3'd3,
    KIND_RELEASED = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_SCAN,
    ST_RESP
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic sweep_run;
    logic sweep_close;
    logic scan_run;
    logic resp_push;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sweep_done;
    logic scan_hit;
    logic can_push;
  } dp_sts_t;

endpackage

### rtl/core/ptsb_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module ptsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/ptsb_ctrl.sv
// controller state machine of the timer slot bank
// depends on ptsb_pkg
`timescale 1ns / 1ps

module ptsb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  ptsb_pkg::cmd_e      in_cmd_i,
  input  ptsb_pkg::dp_sts_t   sts_i,
  output logic                in_ready_o,
  output ptsb_pkg::ctrl_cmd_t cmd_o
);

  ptsb_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ptsb_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ptsb_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          case (in_cmd_i)
            ptsb_pkg::CMD_TICK:  state_d = ptsb_pkg::ST_SWEEP;
            ptsb_pkg::CMD_ALLOC: state_d = ptsb_pkg::ST_SCAN;
            default:             state_d = ptsb_pkg::ST_RESP;
          endcase
        end
      end
      ptsb_pkg::ST_SWEEP: begin
        if (sts_i.sweep_done) state_d = ptsb_pkg::ST_RESP;
      end
      ptsb_pkg::ST_SCAN: begin
        if (sts_i.scan_hit) state_d = ptsb_pkg::ST_RESP;
      end
      ptsb_pkg::ST_RESP: begin
        if (sts_i.can_push) state_d = ptsb_pkg::ST_IDLE;
      end
      default: state_d = ptsb_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ptsb_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ptsb_pkg::ST_SWEEP: begin
        cmd_o.sweep_run   = !sts_i.sweep_done;
        cmd_o.sweep_close = sts_i.sweep_done;
      end
      ptsb_pkg::ST_SCAN: begin
        cmd_o.scan_run = 1'b1;
      end
      ptsb_pkg::ST_RESP: begin
        cmd_o.resp_push = sts_i.can_push;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

### rtl/core/ptsb_dp.sv
// datapath of the timer slot bank: busy marks, slot ram, tick pipeline,
// free slot scan and output register; depends on ptsb_pkg and ptsb_ram
`timescale 1ns / 1ps

module ptsb_dp #(
  parameter int NUM_SLOTS = ptsb_pkg::NUM_SLOTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ptsb_pkg::ctrl_cmd_t           cmd_i,
  output ptsb_pkg::dp_sts_t             sts_o,
  input  ptsb_pkg::cmd_e                in_cmd_i,
  input  logic [ptsb_pkg::TGT_W-1:0]    in_target_i,
  input  logic [ptsb_pkg::IDX_W-1:0]    in_index_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ptsb_pkg::kind_e               out_kind_o,
  output logic [ptsb_pkg::IDX_W-1:0]    out_slot_o,
  output logic                          out_last_o
);

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
  localparam int WORD_W = ptsb_pkg::TGT_W + ptsb_pkg::ELAPSED_W;

  logic [NUM_SLOTS-1:0] busy_q;
  logic [CNT_W-1:0]     ptr_q;
  logic                 ev_valid_q;
  logic                 held_valid_q;
  logic [ptsb_pkg::REP_W-1:0] rep_cnt_q;
  logic                 out_valid_q;

  logic [SLOT_W-1:0]          ev_idx_q;
  logic [SLOT_W-1:0]          held_idx_q;
  logic [ptsb_pkg::TGT_W-1:0] tgt_q;
  ptsb_pkg::kind_e            res_kind_q;
  logic [ptsb_pkg::IDX_W-1:0] res_slot_q;
  ptsb_pkg::kind_e            out_kind_q;
  logic [ptsb_pkg::IDX_W-1:0] out_slot_q;
  logic                       out_last_q;

  logic                           ram_we, ram_re;
  logic [SLOT_W-1:0]              ram_waddr;
  logic [WORD_W-1:0]              ram_wdata, ram_rdata;
  logic [ptsb_pkg::TGT_W-1:0]     rd_tgt;
  logic [ptsb_pkg::ELAPSED_W-1:0] rd_el, el_inc;

  logic [SLOT_W-1:0] ptr_slot, rel_slot;
  logic ptr_lt_n, can_push, ev_busy, fire, report, stall, ev_go;
  logic sweep_push, scan_free, scan_last, rel_ok;

  assign ptr_slot = ptr_q[SLOT_W-1:0];
  assign ptr_lt_n = ptr_q < CNT_W'(NUM_SLOTS);
  assign can_push = !out_valid_q || out_ready_i;

  // tick pipeline: read slot ptr while the previous slot is evaluated
  assign rd_tgt  = ram_rdata[ptsb_pkg::ELAPSED_W +: ptsb_pkg::TGT_W];
  assign rd_el   = ram_rdata[ptsb_pkg::ELAPSED_W-1:0];
  assign el_inc  = rd_el + ptsb_pkg::ELAPSED_W'(1);
  assign ev_busy = ev_valid_q && busy_q[ev_idx_q];
  assign fire    = el_inc > ptsb_pkg::ELAPSED_W'(rd_tgt);
  assign report  = ev_busy && fire && (rep_cnt_q < ptsb_pkg::REP_W'(ptsb_pkg::MAX_RESULTS));
  // a second fired slot pushes the held one out, which needs the output free
  assign stall      = report && held_valid_q && !can_push;
  assign ev_go      = cmd_i.sweep_run && !stall;
  assign sweep_push = ev_go && report && held_valid_q;

  // allocate scan, one busy mark per cycle
  assign scan_free = !busy_q[ptr_slot];
  assign scan_last = ptr_q == CNT_W'(NUM_SLOTS - 1);

  assign rel_ok   = 32'(in_index_i) < 32'(NUM_SLOTS);
  assign rel_slot = SLOT_W'(in_index_i);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ev_idx_q;
    ram_wdata = {rd_tgt, (fire ? '0 : el_inc)};
    if (cmd_i.scan_run && scan_free) begin
      ram_we    = 1'b1;
      ram_waddr = ptr_slot;
      ram_wdata = {tgt_q, {ptsb_pkg::ELAPSED_W{1'b0}}};
    end else if (ev_go && ev_busy) begin
      ram_we = 1'b1;
    end
  end

  assign ram_re = ev_go && ptr_lt_n;

  ptsb_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ptr_slot),
    .rdata_o (ram_rdata)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= '0;
      ptr_q        <= '0;
      ev_valid_q   <= 1'b0;
      held_valid_q <= 1'b0;
      rep_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        ptr_q        <= '0;
        ev_valid_q   <= 1'b0;
        held_valid_q <= 1'b0;
        rep_cnt_q    <= '0;
        if (in_cmd_i == ptsb_pkg::CMD_RELEASE && rel_ok) begin
          busy_q[rel_slot] <= 1'b0;
        end
      end
      if (ev_go) begin
        ev_valid_q <= ptr_lt_n;
        if (ptr_lt_n) ptr_q <= ptr_q + CNT_W'(1);
        if (report) begin
          held_valid_q <= 1'b1;
          rep_cnt_q    <= rep_cnt_q + ptsb_pkg::REP_W'(1);
        end
      end
      if (cmd_i.scan_run) begin
        if (scan_free) begin
          busy_q[ptr_slot] <= 1'b1;
        end else if (!scan_last) begin
          ptr_q <= ptr_q + CNT_W'(1);
        end
      end
      if (sweep_push || cmd_i.resp_push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      tgt_q <= in_target_i;
      if (in_cmd_i == ptsb_pkg::CMD_RELEASE) begin
        res_kind_q <= ptsb_pkg::KIND_RELEASED;
        res_slot_q <= in_index_i;
      end else begin
        res_kind_q <= ptsb_pkg::KIND_NONE;
        res_slot_q <= '0;
      end
    end
    if (ram_re) begin
      ev_idx_q <= ptr_slot;
    end
    if (ev_go && report) begin
      held_idx_q <= ev_idx_q;
    end
    if (cmd_i.scan_run) begin
      if (scan_free) begin
        res_kind_q <= ptsb_pkg::KIND_ALLOC;
        res_slot_q <= ptsb_pkg::IDX_W'(ptr_slot);
      end else if (scan_last) begin
        res_kind_q <= ptsb_pkg::KIND_FULL;
        res_slot_q <= '0;
      end
    end
    if (cmd_i.sweep_close) begin
      res_kind_q <= held_valid_q ? ptsb_pkg::KIND_FIRED : ptsb_pkg::KIND_NONE;
      res_slot_q <= held_valid_q ? ptsb_pkg::IDX_W'(held_idx_q) : '0;
    end
    if (sweep_push) begin
      out_kind_q <= ptsb_pkg::KIND_FIRED;
      out_slot_q <= ptsb_pkg::IDX_W'(held_idx_q);
      out_last_q <= 1'b0;
    end else if (cmd_i.resp_push) begin
      out_kind_q <= res_kind_q;
      out_slot_q <= res_slot_q;
      out_last_q <= 1'b1;
    end
  end

  assign sts_o.sweep_done = !ptr_lt_n && !ev_valid_q;
  assign sts_o.scan_hit   = scan_free || scan_last;
  assign sts_o.can_push   = can_push;

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_slot_o  = out_slot_q;
  assign out_last_o  = out_last_q;

  a_rep_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rep_cnt_q <= ptsb_pkg::REP_W'(ptsb_pkg::MAX_RESULTS))
    else $error("reported fire count beyond limit");

  a_no_rw_same_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ptr_slot))
    else $error("slot ram read and written at the same slot");

  a_held_matches_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sweep_close |-> (held_valid_q == (rep_cnt_q != '0)))
    else $error("held fired slot disagrees with report count");

  a_non_fired_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q != ptsb_pkg::KIND_FIRED) |-> out_last_q)
    else $error("non-fired result not marked last");

endmodule

### rtl/core/periodic_timer_slot_bank.sv
// top level of the periodic timer slot bank: stream ports, controller and datapath
// depends on ptsb_pkg, ptsb_ctrl, ptsb_dp (and ptsb_ram below it)
`timescale 1ns / 1ps

// A bank of NUM_SLOTS periodic timers. Each input item carries a command: a tick
// advances every busy slot by one and reports each slot whose count passed its
// target (period is tick_target + 1 ticks), one result per fired slot in
// ascending order with tlast on the final one, or a single none-fired result;
// an allocate claims the lowest free slot and returns it, or reports no free
// slot; a release frees slot_index and echoes it. At most eight fired slots are
// reported per tick, and slot_number carries the low three bits of the slot.
// Targets and elapsed counts sit in one slot ram with one write and one
// registered read port, so a tick walks the slots one per cycle while the
// output side does not stall. An allocate scans the busy marks one per cycle;
// a release or an unused command code goes straight to its response. One
// item is in work at a time; the result register lets the last result wait
// while a new item is accepted. Reset clears all busy marks; no clearing pass
// is needed.

module periodic_timer_slot_bank #(
  parameter int NUM_SLOTS = ptsb_pkg::NUM_SLOTS_DEF   // 1 to 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // item in
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [1:0] cmd, [17:2] tick_target, [20:18] slot_index, [23:21] zero
  input  logic [ptsb_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // results out
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [2:0] event_kind, [5:3] slot_number, [7:6] zero
  output logic [ptsb_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  output logic                               m_axis_tlast_o   // last_result
);

  ptsb_pkg::ctrl_cmd_t        ctrl_cmd;
  ptsb_pkg::dp_sts_t          dp_sts;
  ptsb_pkg::cmd_e             in_cmd;
  logic [ptsb_pkg::TGT_W-1:0] in_target;
  logic [ptsb_pkg::IDX_W-1:0] in_index;
  ptsb_pkg::kind_e            out_kind;
  logic [ptsb_pkg::IDX_W-1:0] out_slot;

  // unpack the input item
  assign in_cmd    = ptsb_pkg::cmd_e'(s_axis_tdata_i[1:0]);
  assign in_target = s_axis_tdata_i[17:2];
  assign in_index  = s_axis_tdata_i[20:18];

  // sequencing: idle, tick sweep, free slot scan, single response
  ptsb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_cmd_i   (in_cmd),
    .sts_i      (dp_sts),
    .in_ready_o (s_axis_tready_o),
    .cmd_o      (ctrl_cmd)
  );

  // slot state, slot ram and output register
  ptsb_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (ctrl_cmd),
    .sts_o       (dp_sts),
    .in_cmd_i    (in_cmd),
    .in_target_i (in_target),
    .in_index_i  (in_index),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_kind_o  (out_kind),
    .out_slot_o  (out_slot),
    .out_last_o  (m_axis_tlast_o)
  );

  // pack the result item, zero fill to a whole byte
  assign m_axis_tdata_o = {2'b00, out_slot, out_kind};

endmodule

### sim/tb_timer_bank_pkg.sv
// scoreboard for the periodic timer slot bank testbench: slot state, event prediction, checks
// depends on ptsb_pkg for command and event kind codes
`timescale 1ns / 1ps

package tb_timer_bank_pkg;

  typedef struct packed {
    ptsb_pkg::kind_e kind;
    logic [2:0]      slot;
    logic            is_last;
  } timer_event_t;

  class timer_bank_scoreboard;

    localparam int SLOTS = ptsb_pkg::NUM_SLOTS_DEF;

    // shadow copy of the slot bank
    logic        busy_q[SLOTS];
    logic [15:0] target_q[SLOTS];
    logic [16:0] elapsed_q[SLOTS];

    timer_event_t pending_events[$];

    int errors;
    int ticks, allocs, fulls, releases, nops, fired_total, all_fired_ticks;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        busy_q[i]    = 1'b0;
        target_q[i]  = '0;
        elapsed_q[i] = '0;
      end
      errors = 0;
      ticks = 0;
      allocs = 0;
      fulls = 0;
      releases = 0;
      nops = 0;
      fired_total = 0;
      all_fired_ticks = 0;
    endfunction

    function int pending();
      return pending_events.size();
    endfunction

    function void add_event(ptsb_pkg::kind_e kind, logic [2:0] slot, logic is_last);
      timer_event_t ev;
      ev.kind    = kind;
      ev.slot    = slot;
      ev.is_last = is_last;
      pending_events.push_back(ev);
    endfunction

    // update the shadow bank for one accepted command and queue its events
    function void note_command(ptsb_pkg::cmd_e cmd, logic [15:0] tgt, logic [2:0] idx);
      logic [2:0] hits[$];
      bit         placed;
      placed = 1'b0;
      case (cmd)
        ptsb_pkg::CMD_TICK: begin
          ticks++;
          for (int i = 0; i < SLOTS; i++) begin
            if (busy_q[i]) begin
              elapsed_q[i] = elapsed_q[i] + 17'd1;
              if (elapsed_q[i] > {1'b0, target_q[i]}) begin
                elapsed_q[i] = '0;
                // only the first MAX_RESULTS firings are reported
                if (hits.size() < ptsb_pkg::MAX_RESULTS) hits.push_back(3'(i));
              end
            end
          end
          if (hits.size() == 0) begin
            add_event(ptsb_pkg::KIND_NONE, 3'd0, 1'b1);
          end else begin
            fired_total += hits.size();
            if (hits.size() == ptsb_pkg::MAX_RESULTS) all_fired_ticks++;
            foreach (hits[k]) begin
              add_event(ptsb_pkg::KIND_FIRED, hits[k], k == hits.size() - 1);
            end
          end
        end
        ptsb_pkg::CMD_ALLOC: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!placed && !busy_q[i]) begin
              busy_q[i]    = 1'b1;
              target_q[i]  = tgt;
              elapsed_q[i] = '0;
              placed       = 1'b1;
              allocs++;
              add_event(ptsb_pkg::KIND_ALLOC, 3'(i), 1'b1);
            end
          end
          if (!placed) begin
            fulls++;
            add_event(ptsb_pkg::KIND_FULL, 3'd0, 1'b1);
          end
        end
        ptsb_pkg::CMD_RELEASE: begin
          releases++;
          if (int'(idx) < SLOTS) busy_q[idx] = 1'b0;
          add_event(ptsb_pkg::KIND_RELEASED, idx, 1'b1);
        end
        default: begin
          nops++;
          add_event(ptsb_pkg::KIND_NONE, 3'd0, 1'b1);
        end
      endcase
    endfunction

    // compare one accepted result with the oldest queued event
    function void check_result(logic [ptsb_pkg::OUT_DATA_W-1:0] data, logic last);
      timer_event_t want;
      if (pending_events.size() == 0) begin
        $error("result with nothing queued: event_kind %0d slot_number %0d last %0b",
               data[2:0], data[5:3], last);
        errors++;
        return;
      end
      want = pending_events.pop_front();
      if (data[2:0] !== want.kind) begin
        $error("event_kind: expected %0d, got %0d", want.kind, data[2:0]);
        errors++;
      end
      if (data[5:3] !== want.slot) begin
        $error("slot_number: expected %0d, got %0d", want.slot, data[5:3]);
        errors++;
      end
      if (last !== want.is_last) begin
        $error("last_result: expected %0b, got %0b", want.is_last, last);
        errors++;
      end
    endfunction

    // anything still queued at the end never came out
    function void close_out();
      if (pending_events.size() != 0) begin
        $error("%0d results never arrived", pending_events.size());
        errors += pending_events.size();
      end
    endfunction

  endclass

endpackage

### sim/tb_top.sv
// top of the periodic timer slot bank testbench: clock, reset, item driver and result checker
// depends on ptsb_pkg, tb_timer_bank_pkg and the periodic_timer_slot_bank rtl
`timescale 1ns / 1ps

module tb_top;

  localparam int RANDOM_ITEMS = 470;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 3 * ptsb_pkg::NUM_SLOTS_DEF + 12;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [ptsb_pkg::IN_DATA_W-1:0]  s_tdata = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [ptsb_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                            m_tlast;

  tb_timer_bank_pkg::timer_bank_scoreboard bank_sb;

  // sender burst state
  int burst_left = 0;

  // receiver stall pattern state
  int          cycle_count = 0;
  int          stall_left = 0;
  logic [1:0]  stall_mode = 2'd0;

  periodic_timer_slot_bank dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // offer one command item, hold it until taken, then maybe idle for a while
  task automatic send_command(ptsb_pkg::cmd_e cmd, logic [15:0] tgt, logic [2:0] idx);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, idx, tgt, cmd};
    do @(posedge clk); while (!s_tready);
    bank_sb.note_command(cmd, tgt, idx);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // mostly short bursts, now and then a long run with no idling
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 10);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // result side: check each accepted result, stall on a mode that changes over time
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL periodic_timer_slot_bank");
      $finish;
    end
    if (rst_n && m_tvalid && m_tready) bank_sb.check_result(m_tdata, m_tlast);
    if (stall_left == 0) begin
      stall_mode <= 2'($urandom_range(0, 3));
      stall_left <= $urandom_range(20, 120);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      2'd0: m_tready <= 1'b1;                           // never stalls
      2'd1: m_tready <= 1'($urandom_range(0, 1));       // coin flip
      2'd2: m_tready <= ($urandom_range(0, 3) == 0);    // mostly stalled
      default: m_tready <= ((cycle_count % 5) < 2);     // fixed duty cycle
    endcase
  end

  initial begin
    ptsb_pkg::cmd_e cmd;
    logic [15:0]    tgt;
    logic [2:0]     idx;
    int             pick;

    bank_sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty bank tick, unused code, release of an idle slot
    send_command(ptsb_pkg::CMD_TICK, 16'hffff, 3'd7);
    send_command(ptsb_pkg::CMD_NOP, 16'ha5a5, 3'd5);
    send_command(ptsb_pkg::CMD_RELEASE, 16'h0000, 3'd5);
    // fill the bank: seven one-tick periods and the longest period on the top slot
    for (int i = 0; i < 7; i++) send_command(ptsb_pkg::CMD_ALLOC, 16'h0000, 3'(i));
    send_command(ptsb_pkg::CMD_ALLOC, 16'hffff, 3'd0);
    send_command(ptsb_pkg::CMD_ALLOC, 16'h1234, 3'd0);  // bank full
    send_command(ptsb_pkg::CMD_TICK, 16'h0000, 3'd0);   // seven fire, long slot does not
    send_command(ptsb_pkg::CMD_RELEASE, 16'hffff, 3'd7);
    send_command(ptsb_pkg::CMD_ALLOC, 16'h0000, 3'd7);  // refills slot 7
    send_command(ptsb_pkg::CMD_TICK, 16'h5a5a, 3'd2);   // all eight fire
    send_command(ptsb_pkg::CMD_RELEASE, 16'h0000, 3'd0);
    send_command(ptsb_pkg::CMD_RELEASE, 16'h0000, 3'd3);
    send_command(ptsb_pkg::CMD_ALLOC, 16'h0001, 3'd6);  // lowest free slot is 0
    send_command(ptsb_pkg::CMD_TICK, 16'h0000, 3'd0);
    send_command(ptsb_pkg::CMD_TICK, 16'h0000, 3'd0);   // two-tick slot fires here
    send_command(ptsb_pkg::CMD_NOP, 16'h0000, 3'd0);
    send_command(ptsb_pkg::CMD_RELEASE, 16'h0000, 3'd3); // already idle

    // random: ticks most often, allocations mostly with small periods so slots fire often
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      tgt  = 16'($urandom());
      idx  = 3'($urandom_range(0, 7));
      if (pick < 45) begin
        cmd = ptsb_pkg::CMD_TICK;
      end else if (pick < 70) begin
        cmd = ptsb_pkg::CMD_ALLOC;
        pick = $urandom_range(0, 9);
        if (pick < 7) tgt = 16'($urandom_range(0, 5));
        else if (pick < 9) tgt = 16'($urandom_range(0, 40));
      end else if (pick < 92) begin
        cmd = ptsb_pkg::CMD_RELEASE;
      end else begin
        cmd = ptsb_pkg::CMD_NOP;
      end
      send_command(cmd, tgt, idx);
    end
    s_tvalid <= 1'b0;

    while (bank_sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    bank_sb.close_out();

    $display("ran %0d ticks, %0d allocations, %0d full-bank allocations,",
             bank_sb.ticks, bank_sb.allocs, bank_sb.fulls);
    $display("%0d releases, %0d unused codes, %0d slot firings, %0d ticks with every slot firing",
             bank_sb.releases, bank_sb.nops, bank_sb.fired_total, bank_sb.all_fired_ticks);
    if (bank_sb.errors == 0) begin
      $display("PASS periodic_timer_slot_bank");
    end else begin
      $display("FAIL periodic_timer_slot_bank");
    end
    $finish;
  end

endmodule
